// File: hw/rtl/tzr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tzr_pkg
// Shared types, widths and codes of the triangle rasterizer with depth store.
// ----------------------------------------------------------------------------
package tzr_pkg;

    localparam int MAX_WIDTH     = 64;
    localparam int MAX_HEIGHT    = 64;
    localparam int SUBPIXEL_BITS = 4;
    localparam int DEPTH_BITS    = 16;

    localparam int COORD_W   = 12;
    localparam int COLOR_W   = 24;
    localparam int SIZE_W    = 7;
    localparam int COUNT_W   = 13;
    localparam int CFG_IDX_W = 1;

    localparam int PIX_W       = $clog2(MAX_WIDTH);
    localparam int PIY_W       = $clog2(MAX_HEIGHT);
    localparam int PIXQ_W      = COORD_W - SUBPIXEL_BITS;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int DIFF_W      = COORD_W + 1;
    localparam int EDGE_W      = 2 * DIFF_W + 2;
    localparam int SUM_W       = EDGE_W + DEPTH_BITS;
    localparam int RAM_W       = COLOR_W + DEPTH_BITS;
    localparam int DIV_CNT_W   = $clog2(DEPTH_BITS);

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        KIND_DRAW  = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                      kind;
        logic signed [COORD_W-1:0]  vert0_x;
        logic signed [COORD_W-1:0]  vert0_y;
        logic [DEPTH_BITS-1:0]      vert0_depth;
        logic signed [COORD_W-1:0]  vert1_x;
        logic signed [COORD_W-1:0]  vert1_y;
        logic [DEPTH_BITS-1:0]      vert1_depth;
        logic signed [COORD_W-1:0]  vert2_x;
        logic signed [COORD_W-1:0]  vert2_y;
        logic [DEPTH_BITS-1:0]      vert2_depth;
        logic [COLOR_W-1:0]         fill_color;
    } t_item;

    typedef struct packed {
        logic [COLOR_W-1:0]    read_color;
        logic [DEPTH_BITS-1:0] read_depth;
        logic [COUNT_W-1:0]    pixels_written;
    } t_result;

endpackage

// File: hw/rtl/tzr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tzr_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module tzr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

// File: hw/rtl/tzr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tzr_div
// Restoring divider, one quotient bit per cycle, for the depth interpolation.
// ----------------------------------------------------------------------------
module tzr_div
    import tzr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [SUM_W-1:0]      i_dividend,
    input  logic [EDGE_W-1:0]     i_divisor,
    output logic                  o_done,
    output logic [DEPTH_BITS-1:0] o_quot
);

    logic [EDGE_W-1:0]     r_rem;
    logic [DEPTH_BITS-1:0] r_quot;
    logic [EDGE_W-1:0]     r_div;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [EDGE_W:0]       trial;
    logic                  ge;
    logic [EDGE_W:0]       diff;

    assign trial = {r_rem, r_quot[DEPTH_BITS-1]};
    assign ge    = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= i_dividend[SUM_W-1:DEPTH_BITS];
                r_quot <= i_dividend[DEPTH_BITS-1:0];
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem  <= ge ? diff[EDGE_W-1:0] : trial[EDGE_W-1:0];
                r_quot <= {r_quot[DEPTH_BITS-2:0], ge};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DEPTH_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: hw/rtl/triangle_zbuffer_rasterizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_zbuffer_rasterizer_core
// Edge-function triangle rasterizer with a combined color and depth store.
//
//   Port group   Direction  Handshake
//   item         in         start high while busy low
//   result       out        o_done high for one cycle
//   config       in         i_cfg_we high, applied at once
//
// A read answers from S_RDOUT, an unused kind straight from idle, and a clear
// writes one store entry per cycle. A draw runs the set-up steps and S_SIGN,
// then visits each bounding-box pixel; one inside the triangle goes through
// S_MUL, the restoring divider in S_DIV and the depth test in S_WR. After reset
// the store is swept to zero with busy high. Results cannot be stalled.
// ----------------------------------------------------------------------------
module triangle_zbuffer_rasterizer_core
    import tzr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  t_item                i_item,
    output logic                 busy,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SIZE_W-1:0]    i_cfg_data,
    output logic                 o_done,
    output t_result              o_result
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CLR   = 9'b000000010,
        S_RDOUT = 9'b000000100,
        S_SETUP = 9'b000001000,
        S_SIGN  = 9'b000010000,
        S_PIX   = 9'b000100000,
        S_MUL   = 9'b001000000,
        S_DIV   = 9'b010000000,
        S_WR    = 9'b100000000
    } t_state;

    function automatic logic [SIZE_W-1:0] eff_size(logic [SIZE_W-1:0] v,
                                                   logic [SIZE_W-1:0] lim);
        if (v == '0) begin
            return SIZE_W'(1);
        end else if (v > lim) begin
            return lim;
        end
        return v;
    endfunction

    function automatic logic [SIZE_W-1:0] clamp_pix(logic signed [COORD_W-1:0] v,
                                                    logic [SIZE_W-1:0] size);
        logic [PIXQ_W-1:0] p;
        p = v[COORD_W-1:SUBPIXEL_BITS];
        if (v < 0) begin
            return '0;
        end else if (p >= PIXQ_W'(size)) begin
            return size - 1'b1;
        end
        return SIZE_W'(p);
    endfunction

    function automatic logic [ADDR_W-1:0] pix_index(logic [SIZE_W-1:0] h,
                                                    logic [SIZE_W-1:0] w,
                                                    logic [SIZE_W-1:0] y,
                                                    logic [SIZE_W-1:0] x);
        logic [SIZE_W-1:0]   row;
        logic [2*SIZE_W-1:0] prod;
        row  = h - 1'b1 - y;
        prod = row * w;
        return ADDR_W'(prod + (2*SIZE_W)'(x));
    endfunction

    function automatic logic signed [DIFF_W-1:0] sx(logic signed [COORD_W-1:0] v);
        return DIFF_W'(v);
    endfunction

    function automatic logic signed [COORD_W-1:0] min2(logic signed [COORD_W-1:0] a,
                                                       logic signed [COORD_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [COORD_W-1:0] max2(logic signed [COORD_W-1:0] a,
                                                       logic signed [COORD_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    localparam logic [SUBPIXEL_BITS-1:0] HALF_PIX = SUBPIXEL_BITS'(1 << (SUBPIXEL_BITS - 1));

    t_state                    r_state;
    logic [SIZE_W-1:0]         r_cfg_w;
    logic [SIZE_W-1:0]         r_cfg_h;
    t_item                     r_item;
    logic [2:0]                r_step;
    logic signed [EDGE_W-1:0]  r_area;
    logic signed [EDGE_W-1:0]  r_e    [3];
    logic signed [EDGE_W-1:0]  r_ecol [3];
    logic signed [DIFF_W-1:0]  r_a    [3];
    logic signed [DIFF_W-1:0]  r_b    [3];
    logic [PIX_W-1:0]          r_xb;
    logic [PIX_W-1:0]          r_i;
    logic [PIY_W-1:0]          r_ya;
    logic [PIY_W-1:0]          r_yb;
    logic [PIY_W-1:0]          r_j;
    logic [SUM_W-1:0]          r_sum;
    logic [ADDR_W-1:0]         r_addr;
    logic [COUNT_W-1:0]        r_cnt;
    logic [ADDR_W-1:0]         r_clr_addr;
    logic                      r_clr_quiet;
    logic                      r_rd_ok;
    logic                      r_done;
    t_result                   r_res;

    logic [SIZE_W-1:0]         eff_w;
    logic [SIZE_W-1:0]         eff_h;
    logic signed [COORD_W-1:0] vx [3];
    logic signed [COORD_W-1:0] vy [3];
    logic [DEPTH_BITS-1:0]     vz [3];
    logic signed [DIFF_W-1:0]  ca [3];
    logic signed [DIFF_W-1:0]  cb [3];
    logic [SIZE_W-1:0]         bx_lo;
    logic [SIZE_W-1:0]         bx_hi;
    logic [SIZE_W-1:0]         by_lo;
    logic [SIZE_W-1:0]         by_hi;
    logic signed [DIFF_W-1:0]  px0;
    logic signed [DIFF_W-1:0]  py0;
    logic signed [DIFF_W-1:0]  mul_a;
    logic signed [DIFF_W-1:0]  mul_b;
    logic signed [2*DIFF_W-1:0] mul_p;
    logic signed [EDGE_W-1:0]  mul_ext;
    logic                      covered;
    logic [ADDR_W-1:0]         pix_addr;
    logic [EDGE_W-1:0]         ze;
    logic [DEPTH_BITS-1:0]     zz;
    logic [SUM_W-1:0]          zprod;
    logic                      rd_ok;
    logic [ADDR_W-1:0]         rd_addr;
    logic [PIXQ_W-1:0]         rd_x;
    logic [PIXQ_W-1:0]         rd_y;
    logic                      last_i;
    logic                      last_j;
    logic                      advance;
    logic                      accept;
    logic                      div_start;
    logic                      div_done;
    logic [DEPTH_BITS-1:0]     div_quot;
    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_waddr;
    logic [RAM_W-1:0]          ram_wdata;
    logic                      ram_re;
    logic [ADDR_W-1:0]         ram_raddr;
    logic [RAM_W-1:0]          ram_q;
    logic [DEPTH_BITS-1:0]     q_depth;
    logic                      depth_wins;

    assign eff_w  = eff_size(r_cfg_w, SIZE_W'(MAX_WIDTH));
    assign eff_h  = eff_size(r_cfg_h, SIZE_W'(MAX_HEIGHT));
    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    assign vx[0] = r_item.vert0_x;
    assign vy[0] = r_item.vert0_y;
    assign vz[0] = r_item.vert0_depth;
    assign vx[1] = r_item.vert1_x;
    assign vy[1] = r_item.vert1_y;
    assign vz[1] = r_item.vert1_depth;
    assign vx[2] = r_item.vert2_x;
    assign vy[2] = r_item.vert2_y;
    assign vz[2] = r_item.vert2_depth;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ca[k] = sx(vy[(k + 1) % 3]) - sx(vy[(k + 2) % 3]);
            cb[k] = sx(vx[(k + 2) % 3]) - sx(vx[(k + 1) % 3]);
        end
    end

    assign bx_lo = clamp_pix(min2(min2(vx[0], vx[1]), vx[2]), eff_w);
    assign bx_hi = clamp_pix(max2(max2(vx[0], vx[1]), vx[2]), eff_w);
    assign by_lo = clamp_pix(min2(min2(vy[0], vy[1]), vy[2]), eff_h);
    assign by_hi = clamp_pix(max2(max2(vy[0], vy[1]), vy[2]), eff_h);
    assign px0   = $signed(DIFF_W'({bx_lo[PIX_W-1:0], HALF_PIX}));
    assign py0   = $signed(DIFF_W'({by_lo[PIY_W-1:0], HALF_PIX}));

    always_comb begin
        unique case (r_step)
            3'd0: begin mul_a = cb[0]; mul_b = sx(vy[0]) - sx(vy[1]); end
            3'd1: begin mul_a = ca[0]; mul_b = sx(vx[0]) - sx(vx[1]); end
            3'd2: begin mul_a = cb[0]; mul_b = py0 - sx(vy[1]); end
            3'd3: begin mul_a = ca[0]; mul_b = px0 - sx(vx[1]); end
            3'd4: begin mul_a = cb[1]; mul_b = py0 - sx(vy[2]); end
            3'd5: begin mul_a = ca[1]; mul_b = px0 - sx(vx[2]); end
            3'd6: begin mul_a = cb[2]; mul_b = py0 - sx(vy[0]); end
            3'd7: begin mul_a = ca[2]; mul_b = px0 - sx(vx[0]); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign mul_ext = EDGE_W'(mul_p);

    assign covered  = (r_e[0] > 0) && (r_e[1] > 0) && (r_e[2] > 0);
    assign pix_addr = pix_index(eff_h, eff_w, SIZE_W'(r_j), SIZE_W'(r_i));

    always_comb begin
        unique case (r_step[1:0])
            2'd0:    begin ze = $unsigned(r_e[0]); zz = vz[0]; end
            2'd1:    begin ze = $unsigned(r_e[1]); zz = vz[1]; end
            2'd2:    begin ze = $unsigned(r_e[2]); zz = vz[2]; end
            default: begin ze = '0;                zz = '0;    end
        endcase
    end

    assign zprod = ze * zz;

    assign rd_x    = i_item.vert0_x[COORD_W-1:SUBPIXEL_BITS];
    assign rd_y    = i_item.vert0_y[COORD_W-1:SUBPIXEL_BITS];
    assign rd_ok   = !i_item.vert0_x[COORD_W-1] && !i_item.vert0_y[COORD_W-1]
                     && (rd_x < PIXQ_W'(eff_w)) && (rd_y < PIXQ_W'(eff_h));
    assign rd_addr = pix_index(eff_h, eff_w, SIZE_W'(rd_y), SIZE_W'(rd_x));

    assign q_depth    = ram_q[DEPTH_BITS-1:0];
    assign depth_wins = div_quot > q_depth;
    assign last_i     = (r_i == r_xb);
    assign last_j     = (r_j == r_yb);
    assign advance    = ((r_state == S_PIX) && !covered) || (r_state == S_WR);
    assign div_start  = (r_state == S_MUL) && (r_step == 3'd3);

    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = pix_addr;
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = {r_item.fill_color, div_quot};
        if (r_state == S_IDLE) begin
            ram_re    = accept && (i_item.kind == KIND_READ);
            ram_raddr = rd_addr;
        end else if (r_state == S_PIX) begin
            ram_re = covered;
        end else if (r_state == S_CLR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else if (r_state == S_WR) begin
            ram_we = depth_wins;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= SIZE_W'(MAX_WIDTH);
            r_cfg_h <= SIZE_W'(MAX_HEIGHT);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SCREEN_WIDTH:  r_cfg_w <= i_cfg_data;
                CFG_SCREEN_HEIGHT: r_cfg_h <= i_cfg_data;
                default:           r_cfg_w <= r_cfg_w;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_clr_quiet <= 1'b1;
            r_done      <= 1'b0;
            r_step      <= '0;
            r_cnt       <= '0;
            r_rd_ok     <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_item <= i_item;
                        unique case (i_item.kind)
                            KIND_DRAW: begin
                                r_step  <= '0;
                                r_state <= S_SETUP;
                            end
                            KIND_CLEAR: begin
                                r_clr_addr  <= '0;
                                r_clr_quiet <= 1'b0;
                                r_state     <= S_CLR;
                            end
                            KIND_READ: begin
                                r_rd_ok <= rd_ok;
                                r_state <= S_RDOUT;
                            end
                            KIND_NONE: begin
                                r_done <= 1'b1;
                                r_res  <= '0;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
                        r_done      <= !r_clr_quiet;
                        r_res       <= '0;
                        r_clr_quiet <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                S_RDOUT: begin
                    r_done             <= 1'b1;
                    r_res.read_color   <= r_rd_ok ? ram_q[RAM_W-1 -: COLOR_W] : '0;
                    r_res.read_depth   <= r_rd_ok ? q_depth : '0;
                    r_res.pixels_written <= '0;
                    r_state            <= S_IDLE;
                end
                S_SETUP: begin
                    r_step <= r_step + 1'b1;
                    unique case (r_step)
                        3'd0: r_area <= mul_ext;
                        3'd1: r_area <= r_area + mul_ext;
                        3'd2: r_e[0] <= mul_ext;
                        3'd3: r_e[0] <= r_e[0] + mul_ext;
                        3'd4: r_e[1] <= mul_ext;
                        3'd5: r_e[1] <= r_e[1] + mul_ext;
                        3'd6: r_e[2] <= mul_ext;
                        3'd7: begin
                            r_e[2]  <= r_e[2] + mul_ext;
                            r_state <= S_SIGN;
                        end
                        default: r_state <= S_SIGN;
                    endcase
                end
                S_SIGN: begin
                    r_xb  <= bx_hi[PIX_W-1:0];
                    r_ya  <= by_lo[PIY_W-1:0];
                    r_yb  <= by_hi[PIY_W-1:0];
                    r_i   <= bx_lo[PIX_W-1:0];
                    r_j   <= by_lo[PIY_W-1:0];
                    r_cnt <= '0;
                    if (r_area == '0) begin
                        r_done  <= 1'b1;
                        r_res   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        for (int k = 0; k < 3; k++) begin
                            if (r_area < 0) begin
                                r_e[k]    <= -r_e[k];
                                r_ecol[k] <= -r_e[k];
                                r_a[k]    <= -ca[k];
                                r_b[k]    <= -cb[k];
                            end else begin
                                r_ecol[k] <= r_e[k];
                                r_a[k]    <= ca[k];
                                r_b[k]    <= cb[k];
                            end
                        end
                        if (r_area < 0) begin
                            r_area <= -r_area;
                        end
                        r_state <= S_PIX;
                    end
                end
                S_PIX: begin
                    if (covered) begin
                        r_addr  <= pix_addr;
                        r_sum   <= '0;
                        r_step  <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 3'd3) begin
                        r_state <= S_DIV;
                    end else begin
                        r_sum <= r_sum + zprod;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    if (depth_wins) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (advance) begin
                if (last_i && last_j) begin
                    r_done  <= 1'b1;
                    r_res.read_color     <= '0;
                    r_res.read_depth     <= '0;
                    r_res.pixels_written <= r_cnt + COUNT_W'((r_state == S_WR) && depth_wins);
                    r_state <= S_IDLE;
                end else if (last_j) begin
                    r_i     <= r_i + 1'b1;
                    r_j     <= r_ya;
                    r_state <= S_PIX;
                    for (int k = 0; k < 3; k++) begin
                        r_ecol[k] <= r_ecol[k] + (EDGE_W'(r_a[k]) <<< SUBPIXEL_BITS);
                        r_e[k]    <= r_ecol[k] + (EDGE_W'(r_a[k]) <<< SUBPIXEL_BITS);
                    end
                end else begin
                    r_j     <= r_j + 1'b1;
                    r_state <= S_PIX;
                    for (int k = 0; k < 3; k++) begin
                        r_e[k] <= r_e[k] + (EDGE_W'(r_b[k]) <<< SUBPIXEL_BITS);
                    end
                end
            end
        end
    end

    tzr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  ($unsigned(r_area)),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    tzr_ram #(
        .WIDTH (RAM_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    assign o_done   = r_done;
    assign o_result = r_res;

    a_done_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_state == S_IDLE))
        else $error("result strobe outside idle state");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_we)
        else $error("store written while idle");

    a_write_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> $past(r_state == S_DIV))
        else $error("depth test without a finished division");

    a_accept_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted item neither started nor answered");

endmodule
